>>> hdl/pfe_pkg.sv
// Shared types, codes and constants of the three-channel PWM fade engine.
package pfe_pkg;

  localparam int NUM_CH     = 3;
  localparam int LEVEL_W    = 7;
  localparam int PWM_W      = 14;
  localparam int STEP_W     = 15;
  localparam int CNT_W      = 8;
  localparam int MUL_A_W    = 16;
  localparam int MUL_B_W    = LEVEL_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  // Item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADJUST = 2'd1;
  localparam logic [1:0] MODE_ON     = 2'd2;
  localparam logic [1:0] MODE_OFF    = 2'd3;

  // Configuration register indexes
  localparam logic REG_FADE_STEPS = 1'b0;
  localparam logic REG_MIN_LEVEL  = 1'b1;

  // Reset values and limits
  localparam logic [CNT_W-1:0]   FADE_STEPS_RST = 8'd100;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = 7'h08;
  localparam logic [LEVEL_W-1:0] SAVED_RST      = 7'h3F;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 7'h7F;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PWM_W-1:0]   pwm_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Result of the serial divider
  typedef struct packed {
    logic       done;
    pwm_t       quo;
    cnt_t       rem;
  } div_res_t;

endpackage

>>> hdl/pfe_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module pfe_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pfe_pkg::MUL_A_W-1:0]       a,
  input  logic [pfe_pkg::MUL_B_W-1:0]       b,
  output logic                              done,
  output logic [pfe_pkg::MUL_P_W-1:0]       prod
);

  localparam int CW = $clog2(pfe_pkg::MUL_B_W + 1);

  logic [pfe_pkg::MUL_P_W-1:0] acc_r, acc_nxt;
  logic [pfe_pkg::MUL_A_W-1:0] a_r, a_nxt;
  logic [pfe_pkg::MUL_B_W-1:0] b_r, b_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;

  // Shift accumulator, add multiplicand when the top multiplier bit is set
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      a_nxt   = a;
      b_nxt   = b;
      cnt_nxt = CW'(pfe_pkg::MUL_B_W);
    end else if (cnt_r != '0) begin
      acc_nxt = {acc_r[pfe_pkg::MUL_P_W-2:0], 1'b0}
              + (b_r[pfe_pkg::MUL_B_W-1] ? pfe_pkg::MUL_P_W'(a_r) : '0);
      b_nxt   = {b_r[pfe_pkg::MUL_B_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> hdl/pfe_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pfe_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  pfe_pkg::pwm_t             dividend,
  input  pfe_pkg::cnt_t             divisor,
  output pfe_pkg::div_res_t         res
);

  localparam int CW = $clog2(pfe_pkg::PWM_W + 1);

  pfe_pkg::pwm_t  quo_r, quo_nxt;
  pfe_pkg::cnt_t  rem_r, rem_nxt;
  pfe_pkg::cnt_t  dvs_r, dvs_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [pfe_pkg::CNT_W:0] trial;

  // Shift one dividend bit into the remainder, subtract when it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[pfe_pkg::PWM_W-1]} - {1'b0, dvs_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CW'(pfe_pkg::PWM_W);
    end else if (cnt_r != '0) begin
      if (trial[pfe_pkg::CNT_W]) begin
        rem_nxt = {rem_r[pfe_pkg::CNT_W-2:0], quo_r[pfe_pkg::PWM_W-1]};
        quo_nxt = {quo_r[pfe_pkg::PWM_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[pfe_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[pfe_pkg::PWM_W-2:0], 1'b1};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

>>> hdl/three_channel_pwm_fade_engine.sv
// Per item: a tick passes through the tick state, an out-of-range item goes straight
// to the finish state; adjust and switch off form their target with one serial multiply,
// switch on with two (saved-level scaling first), and a long fade adds a serial divide.
// Throughput: one item at a time; the next is taken in the cycle after the previous
// result has been loaded into the output register.
// Reset (rst_n low, synchronous): levels and fades cleared, saved levels 0x3F.
module three_channel_pwm_fade_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  // mode[1:0], channel[3:2], dim_steps[11:4], brightness_delta[19:12],
  // relative_level[35:20], zero fill
  input  logic [pfe_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // compare_high_0[7:0], compare_low_0[15:8], compare_high_1[23:16],
  // compare_low_1[31:24], compare_high_2[39:32], compare_low_2[47:40],
  // level_now[54:48], zero fill
  output logic [pfe_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [pfe_pkg::CNT_W-1:0]          cfg_wdata
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TICK    = 3'd1;
  localparam logic [2:0] ST_MUL_S   = 3'd2;
  localparam logic [2:0] ST_START_T = 3'd3;
  localparam logic [2:0] ST_MUL_T   = 3'd4;
  localparam logic [2:0] ST_START_D = 3'd5;
  localparam logic [2:0] ST_DIV     = 3'd6;
  localparam logic [2:0] ST_FIN     = 3'd7;

  localparam int NCH = pfe_pkg::NUM_CH;
  localparam int LW  = pfe_pkg::LEVEL_W;
  localparam int PW  = pfe_pkg::PWM_W;
  localparam int SW  = pfe_pkg::STEP_W;

  // Input fields
  logic [1:0]          in_mode, in_ch;
  pfe_pkg::cnt_t       in_dsteps;
  logic signed [7:0]   in_delta;
  logic [15:0]         in_rel;
  logic                in_acc;

  assign in_mode   = in_tdata[1:0];
  assign in_ch     = in_tdata[3:2];
  assign in_dsteps = in_tdata[11:4];
  assign in_delta  = $signed(in_tdata[19:12]);
  assign in_rel    = in_tdata[35:20];
  assign in_acc    = in_tvalid && in_tready;

  // Channel state
  pfe_pkg::level_t level_r [NCH];
  pfe_pkg::level_t level_nxt [NCH];
  pfe_pkg::level_t saved_r [NCH];
  pfe_pkg::level_t saved_nxt [NCH];
  pfe_pkg::pwm_t   pwm_r [NCH];
  pfe_pkg::pwm_t   pwm_nxt [NCH];
  pfe_pkg::step_t  step_r [NCH];
  pfe_pkg::step_t  step_nxt [NCH];
  pfe_pkg::cnt_t   left_r [NCH];
  pfe_pkg::cnt_t   left_nxt [NCH];
  pfe_pkg::pwm_t   hold_r [NCH];
  pfe_pkg::pwm_t   hold_nxt [NCH];

  // Configuration and control
  pfe_pkg::cnt_t   fade_steps_r;
  pfe_pkg::level_t min_level_r;
  logic [2:0]      state_r, state_nxt;
  logic [1:0]      ch_r, ch_nxt;
  pfe_pkg::cnt_t   steps_r, steps_nxt;
  pfe_pkg::pwm_t   adiff_r, adiff_nxt;
  logic            neg_r, neg_nxt;
  logic [pfe_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Shared arithmetic units
  logic                           mul_start, div_start, mul_done;
  logic [pfe_pkg::MUL_A_W-1:0]    mul_a;
  logic [pfe_pkg::MUL_B_W-1:0]    mul_b;
  logic [pfe_pkg::MUL_P_W-1:0]    mul_prod;
  pfe_pkg::div_res_t              div_res;

  pfe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (adiff_r),
    .divisor  (steps_r),
    .res      (div_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Scratch values of the sequencer
  logic signed [8:0]  adj_sum;
  logic [pfe_pkg::MUL_P_W-5:0] on_t;
  pfe_pkg::level_t    lvl_cur, sv_cur, lvl_min;
  pfe_pkg::pwm_t      target;
  logic signed [15:0] diff;
  pfe_pkg::pwm_t      diff_abs;
  logic signed [15:0] tick_sum;
  pfe_pkg::level_t    lvl_out;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    steps_nxt     = steps_r;
    adiff_nxt     = adiff_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    level_nxt     = level_r;
    saved_nxt     = saved_r;
    pwm_nxt       = pwm_r;
    step_nxt      = step_r;
    left_nxt      = left_r;
    hold_nxt      = hold_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    lvl_cur       = '0;
    sv_cur        = '0;
    lvl_min       = '0;
    adj_sum       = '0;
    on_t          = '0;
    target        = '0;
    diff          = '0;
    diff_abs      = '0;
    tick_sum      = '0;
    lvl_out       = '0;
    if (in_ch != 2'd3) begin
      lvl_cur = level_r[in_ch];
      sv_cur  = saved_r[in_ch];
    end
    mul_a = in_rel;
    mul_b = sv_cur;
    if (state_r == ST_START_T) begin
      mul_a = pfe_pkg::MUL_A_W'(level_r[ch_r]) + pfe_pkg::MUL_A_W'(2);
      mul_b = level_r[ch_r];
    end

    case (state_r)
      // Take an item and dispatch on its mode
      ST_IDLE: begin
        if (in_acc) begin
          ch_nxt = in_ch;
          if (in_mode == pfe_pkg::MODE_TICK) begin
            state_nxt = ST_TICK;
          end else if (in_ch == 2'd3) begin
            state_nxt = ST_FIN;
          end else begin
            case (in_mode)
              pfe_pkg::MODE_ADJUST: begin
                adj_sum = $signed({2'b00, lvl_cur}) + 9'(in_delta);
                if (adj_sum > $signed({2'b00, pfe_pkg::LEVEL_MAX}))
                  level_nxt[in_ch] = pfe_pkg::LEVEL_MAX;
                else if (adj_sum < 0)
                  level_nxt[in_ch] = '0;
                else
                  level_nxt[in_ch] = adj_sum[LW-1:0];
                steps_nxt = (in_dsteps == '0) ? pfe_pkg::cnt_t'(1) : in_dsteps;
                state_nxt = ST_START_T;
              end
              pfe_pkg::MODE_ON: begin
                mul_start = 1'b1;
                steps_nxt = (fade_steps_r == '0) ? pfe_pkg::cnt_t'(1) : fade_steps_r;
                state_nxt = ST_MUL_S;
              end
              pfe_pkg::MODE_OFF: begin
                saved_nxt[in_ch] = lvl_cur;
                level_nxt[in_ch] = '0;
                steps_nxt = (fade_steps_r == '0) ? pfe_pkg::cnt_t'(1) : fade_steps_r;
                state_nxt = ST_START_T;
              end
              default: begin
                state_nxt = ST_FIN;
              end
            endcase
          end
        end
      end
      // Advance every running fade by one step and latch its compare value
      ST_TICK: begin
        for (int c = 0; c < NCH; c++) begin
          if (left_r[c] != '0) begin
            tick_sum    = $signed({2'b00, pwm_r[c]}) + 16'(step_r[c]);
            pwm_nxt[c]  = tick_sum[PW-1:0];
            hold_nxt[c] = tick_sum[PW-1:0];
            left_nxt[c] = left_r[c] - 1'b1;
          end
        end
        state_nxt = ST_FIN;
      end
      // Scale the saved level and apply the ceiling and floor rules
      ST_MUL_S: begin
        if (mul_done) begin
          on_t    = mul_prod[pfe_pkg::MUL_P_W-1:4];
          sv_cur  = saved_r[ch_r];
          lvl_min = (min_level_r > sv_cur) ? sv_cur : min_level_r;
          if (on_t > ($bits(on_t))'(pfe_pkg::LEVEL_MAX))
            level_nxt[ch_r] = pfe_pkg::LEVEL_MAX;
          else if (($bits(on_t))'(sv_cur) > on_t && ($bits(on_t))'(min_level_r) > on_t)
            level_nxt[ch_r] = lvl_min;
          else
            level_nxt[ch_r] = on_t[LW-1:0];
          state_nxt = ST_START_T;
        end
      end
      // Form the PWM target level*(level+2)
      ST_START_T: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL_T;
      end
      // Compare the difference with the step count
      ST_MUL_T: begin
        if (mul_done) begin
          target   = mul_prod[PW-1:0];
          diff     = $signed({2'b00, target}) - $signed({2'b00, pwm_r[ch_r]});
          diff_abs = diff[15] ? PW'(-diff) : diff[PW-1:0];
          if (diff_abs > PW'(steps_r)) begin
            adiff_nxt = diff_abs;
            neg_nxt   = diff[15];
            state_nxt = ST_START_D;
          end else begin
            if (diff_abs != '0) begin
              step_nxt[ch_r] = diff[15] ? {SW{1'b1}} : SW'(1);
              left_nxt[ch_r] = diff_abs[pfe_pkg::CNT_W-1:0];
            end
            state_nxt = ST_FIN;
          end
        end
      end
      ST_START_D: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      // Apply the remainder at once and arm the step count
      ST_DIV: begin
        if (div_res.done) begin
          step_nxt[ch_r] = neg_r ? SW'(-{1'b0, div_res.quo}) : {1'b0, div_res.quo};
          pwm_nxt[ch_r]  = neg_r ? pwm_r[ch_r] - PW'(div_res.rem)
                                 : pwm_r[ch_r] + PW'(div_res.rem);
          left_nxt[ch_r] = steps_r;
          state_nxt      = ST_FIN;
        end
      end
      // Load the result beat once the output register is free
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          if (ch_r != 2'd3)
            lvl_out = level_r[ch_r];
          out_data_nxt  = {1'b0, lvl_out,
                           hold_r[2][5:0], 2'b00, hold_r[2][PW-1:6],
                           hold_r[1][5:0], 2'b00, hold_r[1][PW-1:6],
                           hold_r[0][5:0], 2'b00, hold_r[0][PW-1:6]};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      fade_steps_r <= pfe_pkg::FADE_STEPS_RST;
      min_level_r  <= pfe_pkg::MIN_LEVEL_RST;
      for (int c = 0; c < NCH; c++) begin
        level_r[c] <= '0;
        saved_r[c] <= pfe_pkg::SAVED_RST;
        pwm_r[c]   <= '0;
        step_r[c]  <= '0;
        left_r[c]  <= '0;
        hold_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == pfe_pkg::REG_FADE_STEPS)
          fade_steps_r <= cfg_wdata;
        else
          min_level_r <= cfg_wdata[LW-1:0];
      end
      level_r <= level_nxt;
      saved_r <= saved_nxt;
      pwm_r   <= pwm_nxt;
      step_r  <= step_nxt;
      left_r  <= left_nxt;
      hold_r  <= hold_nxt;
    end
    ch_r       <= ch_nxt;
    steps_r    <= steps_nxt;
    adiff_r    <= adiff_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // Multiplier results arrive only while the sequencer waits for them
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_S || state_r == ST_MUL_T))
    else $error("multiplier finished outside a multiply state");

  // Divider results arrive only in the divide state
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // An accepted item closes the input until its result is loaded
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second item taken while one is in flight");

  // A result is loaded only from the finish state
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r))
      || $past(state_r == ST_FIN))
    else $error("pending result overwritten");
`endif

endmodule

>>> test/three_channel_pwm_fade_engine_tb.sv
// Self-checking testbench for the three-channel PWM fade engine.
`timescale 1ns / 1ps

module three_channel_pwm_fade_engine_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_HOLD   = 300;

  // One input beat, laid out as on in_tdata (last member in the lowest bits)
  typedef struct packed {
    logic [3:0]        fill;
    logic [15:0]       rel;
    logic signed [7:0] delta;
    logic [7:0]        dsteps;
    logic [1:0]        ch;
    logic [1:0]        mode;
  } fade_item_t;

  // One result beat, laid out as on out_tdata
  typedef struct packed {
    logic            fill;
    pfe_pkg::level_t level_now;
    logic [7:0]      lo2;
    logic [7:0]      hi2;
    logic [7:0]      lo1;
    logic [7:0]      hi1;
    logic [7:0]      lo0;
    logic [7:0]      hi0;
  } fade_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [pfe_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [pfe_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic                           cfg_index = pfe_pkg::REG_FADE_STEPS;
  logic [pfe_pkg::CNT_W-1:0]      cfg_wdata = '0;

  // Engine state as the testbench tracks it
  pfe_pkg::cnt_t   fade_cfg;
  pfe_pkg::level_t min_cfg;
  pfe_pkg::level_t lvl [pfe_pkg::NUM_CH];
  pfe_pkg::level_t saved [pfe_pkg::NUM_CH];
  int              pwm [pfe_pkg::NUM_CH];
  int              step_inc [pfe_pkg::NUM_CH];
  int              steps_left [pfe_pkg::NUM_CH];
  pfe_pkg::pwm_t   hold [pfe_pkg::NUM_CH];

  fade_item_t items_to_send [$];
  fade_res_t  results_due [$];
  fade_item_t item_on_bus;
  bit         beat_taken = 1'b0;
  bit         idle_on = 1'b1;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  int         hold_asked = 0;
  int         hold_seen = 0;
  int         mismatches = 0;
  int         cycles = 0;

  string field_name [7] = '{"compare_high_0", "compare_low_0", "compare_high_1",
                            "compare_low_1", "compare_high_2", "compare_low_2",
                            "level_now"};

  three_channel_pwm_fade_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void reset_engine();
    fade_cfg = pfe_pkg::FADE_STEPS_RST;
    min_cfg  = pfe_pkg::MIN_LEVEL_RST;
    for (int c = 0; c < pfe_pkg::NUM_CH; c++) begin
      lvl[c]        = '0;
      saved[c]      = pfe_pkg::SAVED_RST;
      pwm[c]        = 0;
      step_inc[c]   = 0;
      steps_left[c] = 0;
      hold[c]       = '0;
    end
  endfunction

  // Arm a fade from the current PWM value toward level*(level+2)
  function automatic void arm_fade(int ch, int steps_in);
    int steps;
    int diff;
    int inc;
    steps = (steps_in == 0) ? 1 : steps_in;
    diff  = int'(lvl[ch]) * (int'(lvl[ch]) + 2) - pwm[ch];
    if (diff > steps || diff < -steps) begin
      inc           = diff / steps;
      step_inc[ch]  = inc;
      pwm[ch]      += diff - inc * steps;
      steps_left[ch] = steps;
    end else if (diff > 0) begin
      step_inc[ch]   = 1;
      steps_left[ch] = diff;
    end else if (diff < 0) begin
      step_inc[ch]   = -1;
      steps_left[ch] = -diff;
    end
  endfunction

  // Apply one beat to the tracked state and return the result it causes
  function automatic fade_res_t fade_engine_step(fade_item_t it);
    fade_res_t r;
    int        ch;
    int        t;
    ch = int'(it.ch);
    if (it.mode == pfe_pkg::MODE_TICK) begin
      for (int c = 0; c < pfe_pkg::NUM_CH; c++) begin
        if (steps_left[c] != 0) begin
          pwm[c] += step_inc[c];
          steps_left[c]--;
          hold[c] = pwm[c][pfe_pkg::PWM_W-1:0];
        end
      end
    end else if (ch < pfe_pkg::NUM_CH) begin
      case (it.mode)
        pfe_pkg::MODE_ADJUST: begin
          t = int'(lvl[ch]) + int'($signed(it.delta));
          if (t > int'(pfe_pkg::LEVEL_MAX)) t = int'(pfe_pkg::LEVEL_MAX);
          else if (t < 0) t = 0;
          lvl[ch] = pfe_pkg::level_t'(t);
          arm_fade(ch, int'(it.dsteps));
        end
        pfe_pkg::MODE_ON: begin
          t = (int'(saved[ch]) * int'(it.rel)) >> 4;
          if (t > int'(pfe_pkg::LEVEL_MAX))
            lvl[ch] = pfe_pkg::LEVEL_MAX;
          else if (int'(saved[ch]) > t && int'(min_cfg) > t)
            lvl[ch] = (min_cfg > saved[ch]) ? saved[ch] : min_cfg;
          else
            lvl[ch] = pfe_pkg::level_t'(t);
          arm_fade(ch, int'(fade_cfg));
        end
        default: begin
          saved[ch] = lvl[ch];
          lvl[ch]   = '0;
          arm_fade(ch, int'(fade_cfg));
        end
      endcase
    end
    r.fill      = 1'b0;
    r.hi0       = hold[0][13:6];
    r.lo0       = {hold[0][5:0], 2'b00};
    r.hi1       = hold[1][13:6];
    r.lo1       = {hold[1][5:0], 2'b00};
    r.hi2       = hold[2][13:6];
    r.lo2       = {hold[2][5:0], 2'b00};
    r.level_now = (ch < pfe_pkg::NUM_CH) ? lvl[ch] : '0;
    return r;
  endfunction

  function automatic fade_item_t mk_item(logic [1:0] mode, logic [1:0] ch, int dsteps,
                                         int delta, int rel);
    fade_item_t it;
    it        = '0;
    it.mode   = mode;
    it.ch     = ch;
    it.dsteps = 8'(dsteps);
    it.delta  = 8'(delta);
    it.rel    = 16'(rel);
    return it;
  endfunction

  // Mostly ticks and small changes, with full-range fields mixed in
  function automatic fade_item_t random_item();
    fade_item_t it;
    int         pick;
    it   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) it.mode = pfe_pkg::MODE_TICK;
    else if (pick < 65) it.mode = pfe_pkg::MODE_ADJUST;
    else if (pick < 82) it.mode = pfe_pkg::MODE_ON;
    else it.mode = pfe_pkg::MODE_OFF;
    it.ch     = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.dsteps = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    it.delta  = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'(int'($urandom_range(0, 40)) - 20);
    it.rel    = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    return it;
  endfunction

  // Wait until every beat has gone out and every result has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (items_to_send.size() != 0 || in_tvalid || results_due.size() != 0);
  endtask

  task automatic write_config(pfe_pkg::cnt_t fade, pfe_pkg::level_t floor_lvl);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = pfe_pkg::REG_FADE_STEPS;
    cfg_wdata = fade;
    fade_cfg  = fade;
    @(negedge clk);
    cfg_index = pfe_pkg::REG_MIN_LEVEL;
    cfg_wdata = {1'b0, floor_lvl};
    min_cfg   = floor_lvl;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Predict on every accepted input beat
  always @(posedge clk) begin
    beat_taken = rst_n && in_tvalid && in_tready;
    if (beat_taken)
      results_due.push_back(fade_engine_step(item_on_bus));
  end

  // Drive input beats from the pending queue, with random gaps while idling is on
  always @(negedge clk) begin : feed_input
    logic nv;
    nv = in_tvalid && !beat_taken;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(0, 3);
      end else if (items_to_send.size() != 0) begin
        item_on_bus = items_to_send.pop_front();
        in_tdata   <= item_on_bus;
        nv          = 1'b1;
      end
    end
    in_tvalid <= nv;
  end

  // Drive out_tready: random stalls while idling is on, plus one long hold on request
  always @(negedge clk) begin : pace_output
    logic rdy;
    rdy = 1'b1;
    if (rst_n) begin
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = LONG_HOLD;
        rdy       = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 3);
        rdy        = 1'b0;
      end
    end
    out_tready <= rdy;
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_output
    fade_res_t   want;
    logic [55:0] wv;
    logic [55:0] gv;
    if (rst_n && out_tvalid && out_tready) begin
      gv = out_tdata;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat 0x%014h", gv);
      end else begin
        want = results_due.pop_front();
        wv   = want;
        for (int k = 0; k < 7; k++) begin
          if (gv[8*k +: 8] !== wv[8*k +: 8]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on %s: expected %0d, got %0d", field_name[k],
                       wv[8*k +: 8], gv[8*k +: 8]);
          end
        end
      end
    end
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("three_channel_pwm_fade_engine_tb NOT OK");
      $finish;
    end
  end

  initial begin
    pfe_pkg::cnt_t   fade_set [NUM_PHASES];
    pfe_pkg::level_t min_set [NUM_PHASES];
    fade_set = '{8'd100, 8'd1, 8'd255, 8'd0, 8'd37, 8'd2, 8'd100};
    min_set  = '{7'd8, 7'd0, 7'd127, 7'd64, 7'd127, 7'd1, 7'd8};
    reset_engine();

    // Hold reset, then release at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(fade_set[p], min_set[p]);
      @(posedge clk);
      if (p == 0) begin
        // Directed opening: clamps, zero step count, zero difference, channel 3
        items_to_send.push_back(mk_item(pfe_pkg::MODE_TICK, 2'd0, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd1, 255, 3, 0));
        repeat (3) items_to_send.push_back(mk_item(pfe_pkg::MODE_TICK, 2'd1, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd1, 9, -2, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd0, 0, 127, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_TICK, 2'd0, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd0, 1, 5, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd2, 128, -128, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ON, 2'd2, 0, 0, 'hFFFF));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_OFF, 2'd2, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ON, 2'd2, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ON, 2'd1, 0, 0, 1));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_OFF, 2'd0, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ON, 2'd0, 0, 0, 16));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_OFF, 2'd0, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ON, 2'd0, 0, 0, 8));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd3, 3, 50, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ON, 2'd3, 0, 0, 'hFFFF));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_OFF, 2'd3, 0, 0, 0));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_TICK, 2'd3, 'hFF, -1, 'hFFFF));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd0, 'hAA, -1, 'h5555));
        items_to_send.push_back(mk_item(pfe_pkg::MODE_ADJUST, 2'd1, 'h55, 'h55, 'hAAAA));
        repeat (3) items_to_send.push_back(mk_item(pfe_pkg::MODE_TICK, 2'd2, 0, 0, 0));
      end
      // Block the receiver for a long stretch while beats keep coming
      if (p == 2)
        hold_asked++;
      // No idling on either side in the last phase
      if (p == NUM_PHASES - 1)
        idle_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++)
        items_to_send.push_back(random_item());
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("three_channel_pwm_fade_engine_tb OK");
    else
      $display("three_channel_pwm_fade_engine_tb NOT OK");
    $finish;
  end

endmodule
